FILE: rtl/core/packed_string_field_validator_defines.svh
// Assertion macros for the packed string field validator.
// Included by the top level; no other dependencies.
`ifndef PACKED_STRING_FIELD_VALIDATOR_DEFINES_SVH
`define PACKED_STRING_FIELD_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSFV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSFV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/psfv_pkg.sv
// Shared types and constants of the packed string field validator.
// No dependencies.
package psfv_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 255;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 8;

  typedef enum logic [1:0] {
    ENC_UNTERM    = 2'd0,
    ENC_NULTERM   = 2'd1,
    ENC_MULTIPART = 2'd2,
    ENC_SEQUENCE  = 2'd3
  } encoding_e;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SECS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SECS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_TERM = 3'd4;

  typedef struct packed {
    encoding_e  mode;
    logic [7:0] max_len;
    logic [7:0] min_secs;
    logic [7:0] max_secs;
    logic [7:0] seq_term;
  } cfg_t;

  typedef struct packed {
    logic       string_valid;
    logic [7:0] packed_length;
    logic [7:0] section_count;
  } result_t;

endpackage

FILE: rtl/core/psfv_cfg.sv
// Configuration register file of the packed string field validator.
// Depends on psfv_pkg.
module psfv_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [psfv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psfv_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output psfv_pkg::cfg_t                     cfg_o
);
  import psfv_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes never wait.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:     cfg_d.mode     = encoding_e'(cfg_wdata_i[1:0]);
        REG_MAX_LEN:  cfg_d.max_len  = cfg_wdata_i;
        REG_MIN_SECS: cfg_d.min_secs = cfg_wdata_i;
        REG_MAX_SECS: cfg_d.max_secs = cfg_wdata_i;
        REG_SEQ_TERM: cfg_d.seq_term = cfg_wdata_i;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= ENC_NULTERM;
      cfg_q.max_len  <= 8'd255;
      cfg_q.min_secs <= 8'd0;
      cfg_q.max_secs <= 8'd255;
      cfg_q.seq_term <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/psfv_scan.sv
// Per-byte scanner: string state registers and the one-byte update logic.
// Depends on psfv_pkg.
module psfv_scan #(
  parameter int unsigned BUFFER_BYTES = psfv_pkg::BUFFER_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psfv_pkg::cfg_t    cfg_i,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output psfv_pkg::result_t res_o
);
  import psfv_pkg::*;

  localparam int unsigned PosW = $clog2(BUFFER_BYTES + 1);

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            decided;
    logic            verdict;
    logic [7:0]      len;
    logic [7:0]      secs;
    logic [7:0]      csl;
    logic            prev_nul;
    logic            first_nul;
  } scan_t;

  scan_t st_q, st_d;

  function automatic scan_t settle(scan_t s, logic ok, logic [7:0] len, logic [7:0] secs);
    scan_t r;
    r         = s;
    r.decided = 1'b1;
    r.verdict = ok;
    r.len     = len;
    r.secs    = secs;
    return r;
  endfunction

  function automatic logic [7:0] sat_inc(logic [7:0] v);
    return (v == 8'd255) ? v : v + 8'd1;
  endfunction

  always_comb begin
    logic [8:0] p9;
    logic [8:0] m9;
    logic [8:0] maxl9;
    logic       done;
    scan_t      fin;

    st_d  = st_q;
    res_o = '0;
    p9    = 9'(st_q.pos);
    m9    = {1'b0, cfg_i.max_len};
    maxl9 = m9 - {1'b0, st_q.len} - 9'd1;
    done  = 1'b0;
    fin   = st_q;

    if (take_i) begin
      if (st_q.pos < PosW'(BUFFER_BYTES)) begin
        if (!st_q.decided) begin
          unique case (cfg_i.mode)
            ENC_UNTERM: begin
              if (byte_i == 8'd0) begin
                st_d = settle(st_d, st_q.len <= cfg_i.max_len, st_q.len, 8'd1);
              end else begin
                st_d.len = st_q.len + 8'd1;
              end
            end
            ENC_NULTERM: begin
              if (p9 < m9 && byte_i == 8'd0) begin
                st_d = settle(st_d, 1'b1, 8'(p9 + 9'd1), 8'd1);
              end else if (p9 + 9'd1 >= m9) begin
                st_d = settle(st_d, 1'b0, 8'd0, 8'd0);
              end
            end
            ENC_MULTIPART: begin
              if (st_q.csl == 8'd0 &&
                  (st_q.len >= cfg_i.max_len || st_q.secs >= cfg_i.max_secs)) begin
                st_d = settle(st_d, st_q.secs >= cfg_i.min_secs, st_q.len, st_q.secs);
              end else if (byte_i == 8'd0) begin
                if (st_q.csl == 8'd0 && st_q.secs >= cfg_i.min_secs) begin
                  // empty optional section ends the string
                  st_d = settle(st_d, 1'b1, st_q.len, st_q.secs);
                end else begin
                  st_d.len  = st_q.len + st_q.csl + 8'd1;
                  st_d.secs = sat_inc(st_q.secs);
                  st_d.csl  = 8'd0;
                end
              end else begin
                st_d.csl = st_q.csl + 8'd1;
                if ({1'b0, st_q.len} + {1'b0, st_q.csl} + 9'd1 >= m9) begin
                  st_d = settle(st_d, 1'b0, 8'd0, 8'd0);
                end
              end
            end
            ENC_SEQUENCE: begin
              if (cfg_i.seq_term == 8'd0) begin
                if (p9 == 9'd1 && st_q.first_nul && byte_i == 8'd0) begin
                  // double NUL at the start: empty sequence
                  st_d = settle(st_d, 1'b1, 8'd2, 8'd0);
                end else begin
                  if (p9 == 9'd0) st_d.first_nul = (byte_i == 8'd0);
                  if (p9 < m9) begin
                    if (byte_i == 8'd0) begin
                      if (st_q.prev_nul) begin
                        st_d = settle(st_d, 1'b1, 8'(p9 + 9'd1), st_q.secs);
                        done = 1'b1;
                      end else begin
                        st_d.secs     = sat_inc(st_q.secs);
                        st_d.prev_nul = 1'b1;
                      end
                    end else begin
                      st_d.prev_nul = 1'b0;
                    end
                  end
                  if (!done && p9 >= 9'd1 && p9 + 9'd1 >= m9) begin
                    st_d = settle(st_d, 1'b0, 8'd0, 8'd0);
                  end
                end
              end else if (st_q.csl == 8'd0) begin
                if (st_q.len >= cfg_i.max_len) begin
                  st_d = settle(st_d, 1'b0, 8'd0, 8'd0);
                end else if (byte_i == cfg_i.seq_term) begin
                  st_d = settle(st_d, 1'b1, st_q.len + 8'd1, st_q.secs);
                end else if (maxl9 == 9'd0) begin
                  st_d = settle(st_d, 1'b0, 8'd0, 8'd0);
                end else if (byte_i == 8'd0) begin
                  st_d.len  = st_q.len + 8'd1;
                  st_d.secs = sat_inc(st_q.secs);
                end else begin
                  st_d.csl = 8'd1;
                  if (maxl9 == 9'd1) st_d = settle(st_d, 1'b0, 8'd0, 8'd0);
                end
              end else begin
                if (byte_i == 8'd0) begin
                  st_d.len  = st_q.len + st_q.csl + 8'd1;
                  st_d.secs = sat_inc(st_q.secs);
                  st_d.csl  = 8'd0;
                end else begin
                  st_d.csl = st_q.csl + 8'd1;
                  if ({1'b0, st_q.csl} + 9'd1 == maxl9) begin
                    st_d = settle(st_d, 1'b0, 8'd0, 8'd0);
                  end
                end
              end
            end
          endcase
        end
        st_d.pos = st_q.pos + PosW'(1);
      end

      if (last_i) begin
        fin = st_d;
        if (!fin.decided) begin
          unique case (cfg_i.mode) inside
            ENC_UNTERM: begin
              fin = settle(fin, fin.len <= cfg_i.max_len, fin.len, 8'd1);
            end
            ENC_MULTIPART: begin
              if (fin.csl == 8'd0 &&
                  (fin.len >= cfg_i.max_len || fin.secs >= cfg_i.max_secs)) begin
                fin = settle(fin, fin.secs >= cfg_i.min_secs, fin.len, fin.secs);
              end else begin
                fin = settle(fin, 1'b0, 8'd0, 8'd0);
              end
            end
            ENC_NULTERM, ENC_SEQUENCE: begin
              fin = settle(fin, 1'b0, 8'd0, 8'd0);
            end
          endcase
        end
        res_o.string_valid  = fin.verdict;
        res_o.packed_length = fin.verdict ? fin.len : 8'd0;
        res_o.section_count = fin.verdict ? fin.secs : 8'd0;
        st_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

FILE: rtl/core/packed_string_field_validator.sv
// Channel   | Direction | Handshake                     | Beat payload
// data      | in        | data_valid_i / data_stall_o   | data_byte_i, last_byte_i
// result    | out       | result_valid_o / result_stall_i | string_valid_o, packed_length_o,
//           |           |                               |   section_count_o
// cfg       | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_wdata_i
//
// One byte per cycle sustained. A byte lands in the input register, and the scanner
// updates the string state from it once it takes the byte from there; on the last byte
// the verdict is loaded into the result register, so the result shows once the last
// beat has passed the input register and the result register. The only stall is a last
// byte meeting a full, stalled result register. Reset clears the configuration to its
// defaults and the string state to empty; cfg_ready_o is always high.
//
// Top level of the packed string field validator.
// Depends on psfv_pkg, psfv_cfg, psfv_scan and the assertion macro header.
`include "packed_string_field_validator_defines.svh"

module packed_string_field_validator #(
  parameter int unsigned BUFFER_BYTES = psfv_pkg::BUFFER_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte stream
  input  logic                            data_valid_i,
  output logic                            data_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_byte_i,
  // verdict stream
  output logic                            result_valid_o,
  input  logic                            result_stall_i,
  output logic                            string_valid_o,
  output logic [7:0]                      packed_length_o,
  output logic [7:0]                      section_count_o,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [psfv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [psfv_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import psfv_pkg::*;

  cfg_t    cfg;
  result_t scan_res;

  // Input register: one byte beat waiting for the scanner.
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register.
  logic       out_vld_q, out_vld_d;
  result_t    out_res_q;

  logic out_free;   // result register can take a new verdict this cycle
  logic scan_take;  // scanner consumes the held byte this cycle
  logic in_load;    // input register takes a new beat

  assign out_free  = !out_vld_q || !result_stall_i;
  // A non-final byte never needs the result register; a last byte waits for it.
  assign scan_take = in_vld_q && (!in_last_q || out_free);
  assign data_stall_o = in_vld_q && !scan_take;
  assign in_load   = data_valid_i && !data_stall_o;

  assign in_vld_d  = in_load || (in_vld_q && !scan_take);
  assign out_vld_d = (scan_take && in_last_q) || (out_vld_q && result_stall_i);

  psfv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  psfv_scan #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .take_i (scan_take),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload: hold the byte until the scanner takes it, hold the verdict while stalled.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (scan_take && in_last_q) begin
      out_res_q <= scan_res;
    end
  end

  assign result_valid_o  = out_vld_q;
  assign string_valid_o  = out_res_q.string_valid;
  assign packed_length_o = out_res_q.packed_length;
  assign section_count_o = out_res_q.section_count;

  // An invalid verdict carries zero length and zero sections.
  `PSFV_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, result_valid_o && !string_valid_o, packed_length_o == 8'd0 && section_count_o == 8'd0, "invalid verdict with nonzero payload")
  // Back-pressure only from a last byte blocked by a stalled verdict.
  `PSFV_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, data_stall_o, in_vld_q && in_last_q && out_vld_q && result_stall_i, "input stalled without a blocked verdict")
  // A consumed last byte always produces a verdict beat.
  `PSFV_ASSERT_NXT(a_last_gives_result, clk_i, rst_ni, scan_take && in_last_q, result_valid_o, "last byte consumed but no verdict")

endmodule

FILE: tb/psfv_tb_pkg.sv
// Verdict board for the packed string field validator testbench.
// Holds a cycle-free predictor of the string checks and the queue of verdicts it expects.
// Depends on psfv_pkg.
package psfv_tb_pkg;
  import psfv_pkg::*;

  class string_verdict_board;
    // register copy
    encoding_e   mode;
    bit [7:0]    max_len;
    bit [7:0]    min_secs;
    bit [7:0]    max_secs;
    bit [7:0]    seq_term;
    // per-string scan state
    int unsigned byte_pos;
    int unsigned len_acc;
    int unsigned secs;
    int unsigned cur_len;
    bit          decided;
    bit          verdict_ok;
    bit          prev_nul;
    bit          first_nul;
    // verdicts owed by the block, oldest first
    result_t     pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      mode     = ENC_NULTERM;
      max_len  = 8'd255;
      min_secs = 8'd0;
      max_secs = 8'd255;
      seq_term = 8'd0;
      errors   = 0;
      checked  = 0;
      clear_string();
    endfunction

    function void clear_string();
      byte_pos   = 0;
      len_acc    = 0;
      secs       = 0;
      cur_len    = 0;
      decided    = 1'b0;
      verdict_ok = 1'b0;
      prev_nul   = 1'b0;
      first_nul  = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_MODE:     mode     = encoding_e'(val[1:0]);
        REG_MAX_LEN:  max_len  = val;
        REG_MIN_SECS: min_secs = val;
        REG_MAX_SECS: max_secs = val;
        REG_SEQ_TERM: seq_term = val;
        default: ;
      endcase
    endfunction

    function void settle(bit ok, int unsigned len, int unsigned n);
      decided    = 1'b1;
      verdict_ok = ok;
      len_acc    = len & 32'hFF;
      secs       = (n > 255) ? 255 : n;
    endfunction

    function void bump_secs();
      if (secs < 255) secs++;
    endfunction

    // Multipart loop head: close the scan once the length or section budget is used up.
    function bit multipart_head();
      if (len_acc >= max_len || secs >= max_secs) begin
        settle(secs >= min_secs, len_acc, secs);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void scan_byte(int unsigned p, int unsigned b);
      int unsigned m;
      int unsigned maxl;
      m = max_len;
      case (mode)
        ENC_UNTERM: begin
          if (b == 0) settle(len_acc <= m, len_acc, 1);
          else len_acc++;
        end
        ENC_NULTERM: begin
          if (p < m && b == 0) settle(1'b1, p + 1, 1);
          else if (p + 1 >= m) settle(1'b0, 0, 0);
        end
        ENC_MULTIPART: begin
          if (cur_len == 0 && multipart_head()) return;
          if (b == 0) begin
            if (cur_len == 0 && secs >= min_secs) begin
              settle(1'b1, len_acc, secs);
              return;
            end
            len_acc += cur_len + 1;
            bump_secs();
            cur_len = 0;
          end else begin
            cur_len++;
            if (len_acc + cur_len >= m) settle(1'b0, 0, 0);
          end
        end
        default: begin
          if (seq_term == 8'd0) begin
            if (p == 1 && first_nul && b == 0) begin
              settle(1'b1, 2, 0);
              return;
            end
            if (p == 0) first_nul = (b == 0);
            if (p < m) begin
              if (b == 0) begin
                if (prev_nul) begin
                  settle(1'b1, p + 1, secs);
                  return;
                end
                bump_secs();
                prev_nul = 1'b1;
              end else begin
                prev_nul = 1'b0;
              end
            end
            if (p >= 1 && p + 1 >= m) settle(1'b0, 0, 0);
          end else if (cur_len == 0) begin
            if (len_acc >= m) begin
              settle(1'b0, 0, 0);
              return;
            end
            if (b == seq_term) begin
              settle(1'b1, len_acc + 1, secs);
              return;
            end
            maxl = m - len_acc - 1;
            if (maxl == 0) begin
              settle(1'b0, 0, 0);
              return;
            end
            if (b == 0) begin
              len_acc++;
              bump_secs();
              return;
            end
            cur_len = 1;
            if (cur_len == maxl) settle(1'b0, 0, 0);
          end else begin
            maxl = m - len_acc - 1;
            if (b == 0) begin
              len_acc += cur_len + 1;
              bump_secs();
              cur_len = 0;
            end else begin
              cur_len++;
              if (cur_len == maxl) settle(1'b0, 0, 0);
            end
          end
        end
      endcase
    endfunction

    function void close_string();
      if (decided) return;
      if (mode == ENC_UNTERM) begin
        settle(len_acc <= max_len, len_acc, 1);
      end else if (mode == ENC_MULTIPART) begin
        if (cur_len == 0 && multipart_head()) return;
        settle(1'b0, 0, 0);
      end else begin
        settle(1'b0, 0, 0);
      end
    endfunction

    // Account for one accepted byte beat; a last byte queues the verdict.
    function void note_byte(logic [7:0] b, logic last);
      result_t v;
      if (byte_pos < BUFFER_BYTES_DEF) begin
        if (!decided) scan_byte(byte_pos, b);
        byte_pos++;
      end
      if (last) begin
        close_string();
        v.string_valid  = verdict_ok;
        v.packed_length = verdict_ok ? len_acc[7:0] : 8'd0;
        v.section_count = verdict_ok ? secs[7:0] : 8'd0;
        pending.push_back(v);
        clear_string();
      end
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected verdict valid=%0d len=%0d secs=%0d", $time,
                 got.string_valid, got.packed_length, got.section_count);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.string_valid !== want.string_valid) begin
        $display("%0t: string_valid expected %0d, got %0d", $time,
                 want.string_valid, got.string_valid);
        errors++;
      end
      if (got.packed_length !== want.packed_length) begin
        $display("%0t: packed_length expected %0d, got %0d", $time,
                 want.packed_length, got.packed_length);
        errors++;
      end
      if (got.section_count !== want.section_count) begin
        $display("%0t: section_count expected %0d, got %0d", $time,
                 want.section_count, got.section_count);
        errors++;
      end
    endfunction

    // Report every verdict that never showed up and forget it.
    function void flush_missing();
      while (pending.size() != 0) begin
        $display("%0t: missing verdict, expected valid=%0d len=%0d secs=%0d", $time,
                 pending[0].string_valid, pending[0].packed_length,
                 pending[0].section_count);
        errors++;
        void'(pending.pop_front());
      end
    endfunction
  endclass

endpackage

FILE: tb/packed_string_field_validator_tb.sv
// Testbench top for the packed string field validator: directed strings, then random
// register settings with mostly well-formed strings, with idle and stall gaps on both sides.
// Depends on psfv_pkg, psfv_tb_pkg and the validator RTL.
module packed_string_field_validator_tb;
  import psfv_pkg::*;
  import psfv_tb_pkg::*;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  data_valid_i   = 1'b0;
  logic                  data_stall_o;
  logic [7:0]            data_byte_i    = 8'h00;
  logic                  last_byte_i    = 1'b0;
  logic                  result_valid_o;
  logic                  result_stall_i = 1'b0;
  logic                  string_valid_o;
  logic [7:0]            packed_length_o;
  logic [7:0]            section_count_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;

  string_verdict_board verdicts = new();

  // register setting the string generator shapes its content for
  cfg_t        cur_cfg;
  bit [7:0]    str_q[$];
  bit          quiet_stretch = 1'b0;
  int unsigned bytes_sent    = 0;
  int unsigned strings_sent  = 0;
  int unsigned settings_used = 0;

  packed_string_field_validator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_valid_i    (data_valid_i),
    .data_stall_o    (data_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .result_valid_o  (result_valid_o),
    .result_stall_i  (result_stall_i),
    .string_valid_o  (string_valid_o),
    .packed_length_o (packed_length_o),
    .section_count_o (section_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stall the result side now and then; hold it open during the quiet stretch.
  always @(negedge clk_i) begin
    result_stall_i <= !quiet_stretch && ($urandom_range(0, 99) < 8);
  end

  // Take a verdict beat at every edge where it is valid and not stalled.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      got.string_valid  = string_valid_o;
      got.packed_length = packed_length_o;
      got.section_count = section_count_o;
      verdicts.check_verdict(got);
    end
  end

  // Drive one byte beat. Called at a falling edge, returns at a falling edge with valid
  // still high so that back-to-back beats never drop valid in between.
  task automatic push_byte(input bit [7:0] b, input bit last);
    while (!quiet_stretch && $urandom_range(0, 99) < 8) begin
      data_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    data_valid_i <= 1'b1;
    data_byte_i  <= b;
    last_byte_i  <= last;
    do @(posedge clk_i); while (data_stall_o);
    verdicts.note_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string();
    foreach (str_q[i]) push_byte(str_q[i], i == str_q.size() - 1);
    strings_sent++;
  endtask

  // Drop valid, wait for every owed verdict (bounded), then let the pipeline settle.
  task automatic drain_verdicts();
    int unsigned waited;
    waited = 0;
    data_valid_i <= 1'b0;
    while (verdicts.pending.size() != 0 && waited < 400) begin
      @(negedge clk_i);
      waited++;
    end
    verdicts.flush_missing();
    repeat (4) @(negedge clk_i);
  endtask

  // Register write beat; valid is left high for the next write and dropped by the caller.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    verdicts.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Write every register while idle. Junk in the upper mode bits must be ignored, and
  // with stray set, writes to the unused indexes go first and must change nothing.
  task automatic apply_config(input cfg_t c, input bit stray);
    drain_verdicts();
    if (stray) begin
      for (int k = 1; k <= 3; k++) begin
        write_reg(REG_SEQ_TERM + CFG_IDX_W'(k), 8'($urandom_range(0, 255)));
      end
    end
    write_reg(REG_MODE, {6'($urandom_range(0, 63)), c.mode});
    write_reg(REG_MAX_LEN, c.max_len);
    write_reg(REG_MIN_SECS, c.min_secs);
    write_reg(REG_MAX_SECS, c.max_secs);
    write_reg(REG_SEQ_TERM, c.seq_term);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    cur_cfg = c;
    settings_used++;
  endtask

  // Content byte: never NUL, never the sequence terminator.
  function automatic bit [7:0] body_byte();
    bit [7:0] v;
    do v = 8'($urandom_range(1, 255)); while (v == cur_cfg.seq_term);
    return v;
  endfunction

  function automatic void add_body(int unsigned n);
    repeat (n) str_q.push_back(body_byte());
  endfunction

  // Build one buffer. Mostly well-formed for the current mode with random content,
  // then a little padding; some are cut short and some are pure noise.
  function automatic void build_string(bit long_one);
    int unsigned shape;
    int unsigned span;
    int unsigned n;
    int unsigned r;
    str_q.delete();
    shape = $urandom_range(0, 99);
    span  = (cur_cfg.max_len > 28) ? 30 : cur_cfg.max_len + 2;
    if (long_one) begin
      // runs past the buffer size, so the tail must be ignored
      n = $urandom_range(256, 262);
      repeat (n) begin
        if (cur_cfg.mode != ENC_UNTERM && $urandom_range(0, 99) < 3) str_q.push_back(8'h00);
        else str_q.push_back(body_byte());
      end
    end else if (shape < 15) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 30)      str_q.push_back(8'h00);
        else if (r < 40) str_q.push_back(cur_cfg.seq_term);
        else             str_q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      case (cur_cfg.mode) inside
        ENC_UNTERM, ENC_NULTERM: begin
          add_body($urandom_range(0, span));
          if (cur_cfg.mode == ENC_NULTERM || $urandom_range(0, 1)) str_q.push_back(8'h00);
        end
        ENC_MULTIPART: begin
          n = $urandom_range(0, (cur_cfg.max_secs > 6) ? 8 : cur_cfg.max_secs + 2);
          repeat (n) begin
            add_body(($urandom_range(0, 99) < 20) ? 0 : $urandom_range(1, 4));
            str_q.push_back(8'h00);
          end
          // an empty section closes the string once enough sections exist
          if ($urandom_range(0, 99) < 70) str_q.push_back(8'h00);
        end
        default: begin
          if (cur_cfg.seq_term == 8'd0 && $urandom_range(0, 99) < 12) begin
            // double NUL right at the start
            str_q.push_back(8'h00);
            str_q.push_back(8'h00);
          end else begin
            n = $urandom_range(0, 5);
            repeat (n) begin
              if (cur_cfg.seq_term == 8'd0) add_body($urandom_range(1, 4));
              else add_body($urandom_range(0, 4));
              str_q.push_back(8'h00);
            end
            str_q.push_back(cur_cfg.seq_term);
          end
        end
      endcase
      repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom_range(0, 255)));
      // cut the stream before the decision now and then
      if (str_q.size() > 1 && $urandom_range(0, 99) < 12) begin
        n = $urandom_range(1, str_q.size() - 1);
        while (str_q.size() > n) void'(str_q.pop_back());
      end
    end
    if (str_q.size() == 0) str_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Pick a register setting; every third phase goes to the extremes.
  function automatic cfg_t pick_config(int unsigned phase);
    cfg_t c;
    c.mode = encoding_e'(phase % 4);
    if (phase % 3 == 0) begin
      case ($urandom_range(0, 3))
        0:       c.max_len = 8'd0;
        1:       c.max_len = 8'd1;
        2:       c.max_len = 8'd2;
        default: c.max_len = 8'd255;
      endcase
      c.min_secs = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      c.max_secs = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      c.seq_term = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end else begin
      c.max_len  = ($urandom_range(0, 99) < 20) ? 8'd255 : 8'($urandom_range(0, 24));
      c.min_secs = 8'($urandom_range(0, 4));
      c.max_secs = ($urandom_range(0, 99) < 20) ? 8'd255 : 8'($urandom_range(0, 6));
      c.seq_term = ($urandom_range(0, 99) < 40) ? 8'd0 : 8'($urandom_range(1, 255));
    end
    return c;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned count;
    cur_cfg = '{ENC_NULTERM, 8'd255, 8'd0, 8'd255, 8'd0};

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset setting, NUL terminated, with 0xFF content and a bare NUL.
    str_q = '{8'hFF, 8'h00};
    send_string();
    str_q = '{8'h00};
    send_string();

    // Unterminated with a one-byte limit: fits, then one byte too long.
    apply_config('{ENC_UNTERM, 8'd1, 8'd0, 8'd255, 8'd0}, 1'b1);
    str_q = '{8'h80};
    send_string();
    str_q = '{8'h7F, 8'h01};
    send_string();

    // Multipart: one section, then an empty one closes the string.
    apply_config('{ENC_MULTIPART, 8'd255, 8'd1, 8'd2, 8'd0}, 1'b0);
    str_q = '{8'h61, 8'h00, 8'h00};
    send_string();

    // Sequence with NUL pairs: the leading double NUL, then one section.
    apply_config('{ENC_SEQUENCE, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b0);
    str_q = '{8'h00, 8'h00};
    send_string();
    str_q = '{8'h55, 8'h00, 8'h00};
    send_string();

    // Sequence with a byte terminator: an empty section, then the terminator.
    apply_config('{ENC_SEQUENCE, 8'd255, 8'd0, 8'd255, 8'hFF}, 1'b0);
    str_q = '{8'h00, 8'hFF};
    send_string();

    // NUL terminated with no room at all.
    apply_config('{ENC_NULTERM, 8'd0, 8'd0, 8'd255, 8'd0}, 1'b0);
    str_q = '{8'h00};
    send_string();

    // Random phases until enough bytes and verdicts have gone through.
    phase = 0;
    while ((bytes_sent < 600 || verdicts.checked < 60) && phase < 200) begin
      // one long stretch with no gaps on either side
      quiet_stretch = (phase >= 4 && phase < 8);
      apply_config(pick_config(phase), 1'b0);
      count = $urandom_range(4, 10);
      for (int unsigned s = 0; s < count; s++) begin
        build_string(cur_cfg.max_len == 8'd255 && s == 0 && $urandom_range(0, 1));
        send_string();
      end
      phase++;
    end
    quiet_stretch = 1'b0;

    drain_verdicts();
    repeat (10) @(negedge clk_i);

    $display("Covered %0d bytes in %0d strings across %0d register settings;",
             bytes_sent, strings_sent, settings_used);
    $display("%0d verdicts compared, %0d mismatches.", verdicts.checked, verdicts.errors);
    if (verdicts.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
